>>> rtl/core/mschd_pkg.sv
`default_nettype none
package mschd_pkg;

   // field and table geometry
   localparam int SPEED_W      = 16;
   localparam int LEVEL_W      = 7;
   localparam int DUTY_W       = 7;
   localparam int POINT_W      = 8;
   localparam int TABLE_WORDS  = 4;
   localparam int WORD_POINTS  = 7;
   localparam int TABLE_POINTS = TABLE_WORDS * WORD_POINTS;
   localparam int TWORD_W      = WORD_POINTS * POINT_W;
   localparam int PIDX_W       = $clog2(TABLE_POINTS + 1);
   localparam int BASIC_W      = 24;

   // configuration port
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;

   // default queue depth between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // arithmetic constants
   localparam logic [SPEED_W-1:0] SPEED_SAT  = 16'd32768;
   localparam int                 SPEED_SHIFT = 15;
   localparam logic [DUTY_W-1:0]  PCT_FULL   = 7'd100;
   localparam logic [DUTY_W-1:0]  PCT_OFF    = 7'd0;
   localparam logic [LEVEL_W-1:0] KNEE       = 7'd50;
   localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 7'd0;
   localparam logic [PIDX_W-1:0]  TABLE_LAST = 5'd27;
   // floor(27x/100) = (x * 27 * ceil(2^19/100)) >> 19, exact for x <= 100
   localparam int IDX_RECIP   = 141561;
   localparam int IDX_SHIFT   = 19;
   // floor(v/510) = (v * ceil(2^25/510)) >> 25, exact for v < 66000
   localparam int DIV_RECIP   = 65794;
   localparam int DIV_SHIFT   = 25;
   localparam int ROUND_BIAS  = 255;

   // register map, index = paddr / 8
   typedef enum logic [2:0] {
      REG_REVERSE = 3'd0,
      REG_MODE    = 3'd1,
      REG_BASIC   = 3'd2,
      REG_TABLE0  = 3'd3,
      REG_TABLE1  = 3'd4,
      REG_TABLE2  = 3'd5,
      REG_TABLE3  = 3'd6
   } csr_reg_type;

   // command class decided by the front
   typedef enum logic [1:0] {
      CMD_DRIVE,
      CMD_TURN,
      CMD_ESTOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic                fwd;
      logic [LEVEL_W-1:0]  x;
   } cmd_type;

   typedef logic [TABLE_WORDS-1:0][TWORD_W-1:0]  tbl_words_type;
   typedef logic [TABLE_POINTS-1:0][POINT_W-1:0] tbl_bytes_type;

   typedef struct packed {
      logic                reverse;
      logic                mode;
      logic [BASIC_W-1:0]  basic;
      tbl_words_type       tbl;
   } cfg_type;

   // back end sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BRAKE,
      ST_STOP,
      ST_SETUP,
      ST_LOAD_LO,
      ST_LOAD_HI,
      ST_CALC,
      ST_DIV,
      ST_EMIT
   } back_state_type;

endpackage
`default_nettype wire

>>> rtl/core/motor_speed_curve_hbridge_duty.sv
// Speed command to H-bridge duty.
// Request channel (req_*): one word per speed command: estop, direction and
// speed in mph (Q8.8). Response channel (rsp_*): one or two words per command,
// the last one flagged by rsp_last_result. A word with rsp_hold_1ms set is a
// brake (both legs at 100) that must be held 1 ms before the next word.
// Both channels move a word when valid is high and stall is low.
// Configuration goes through the csr_* APB port, 8-byte register stride.
// A small command queue sits between the front (classify, level) and the
// back sequencer, so requests are taken while a response waits on stall.
// Per command the back sequencer steps through setup, calc, div and emit for
// the three-point curve. The table adds two point reads from the table
// registers (load lo, load hi), and a brake word adds a brake state; an estop
// goes through brake and stop. It pops the next command only after loading
// the last word of the current one, so throughput is set by that sequencer.
// Reset clears the queue, the output register and the remembered direction
// (reverse), and sets all configuration registers to 0. A stalled response
// holds its word; once the queue fills, req_stall rises.
`default_nettype none
module motor_speed_curve_hbridge_duty
   import mschd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_estop,
   input  wire logic                  req_forward,
   input  wire logic [SPEED_W-1:0]    req_speed_mph_q8,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [DUTY_W-1:0]          rsp_duty_a,
   output logic [DUTY_W-1:0]          rsp_duty_b,
   output logic                       rsp_hold_1ms,
   output logic                       rsp_last_result,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic                 reverse_ff;
   logic                 mode_ff;
   logic [BASIC_W-1:0]   basic_ff;
   tbl_words_type        tbl_ff;
   logic                 csr_wr;
   logic [2:0]           csr_idx;
   cfg_type              cfg;

   logic                 queue_full, queue_empty, queue_push, queue_pop;
   cmd_type              push_cmd, head_cmd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[5:3];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
         mode_ff    <= 1'b0;
         basic_ff   <= '0;
         tbl_ff     <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_REVERSE: reverse_ff <= csr_pwdata[0];
            REG_MODE:    mode_ff    <= csr_pwdata[0];
            REG_BASIC:   basic_ff   <= csr_pwdata[BASIC_W-1:0];
            REG_TABLE0:  tbl_ff[0]  <= csr_pwdata[TWORD_W-1:0];
            REG_TABLE1:  tbl_ff[1]  <= csr_pwdata[TWORD_W-1:0];
            REG_TABLE2:  tbl_ff[2]  <= csr_pwdata[TWORD_W-1:0];
            REG_TABLE3:  tbl_ff[3]  <= csr_pwdata[TWORD_W-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         REG_REVERSE: csr_prdata = CSR_DATA_W'(reverse_ff);
         REG_MODE:    csr_prdata = CSR_DATA_W'(mode_ff);
         REG_BASIC:   csr_prdata = CSR_DATA_W'(basic_ff);
         REG_TABLE0:  csr_prdata = CSR_DATA_W'(tbl_ff[0]);
         REG_TABLE1:  csr_prdata = CSR_DATA_W'(tbl_ff[1]);
         REG_TABLE2:  csr_prdata = CSR_DATA_W'(tbl_ff[2]);
         REG_TABLE3:  csr_prdata = CSR_DATA_W'(tbl_ff[3]);
         default:     csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.reverse = reverse_ff;
      cfg.mode    = mode_ff;
      cfg.basic   = basic_ff;
      cfg.tbl     = tbl_ff;
   end

   mschd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_estop        (req_estop),
      .req_forward      (req_forward),
      .req_speed_mph_q8 (req_speed_mph_q8),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_cmd        (push_cmd)
   );

   mschd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (queue_push),
      .wr_cmd (push_cmd),
      .pop    (queue_pop),
      .rd_cmd (head_cmd),
      .full   (queue_full),
      .empty  (queue_empty)
   );

   mschd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head_cmd        (head_cmd),
      .queue_empty     (queue_empty),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_duty_a      (rsp_duty_a),
      .rsp_duty_b      (rsp_duty_b),
      .rsp_hold_1ms    (rsp_hold_1ms),
      .rsp_last_result (rsp_last_result)
   );

   // a brake word drives both legs full and is never the last word
   a_brake_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hold_1ms |->
         rsp_duty_a == PCT_FULL && rsp_duty_b == PCT_FULL && !rsp_last_result)
      else $error("brake word malformed");

   // every word that is not last is a brake
   a_first_is_brake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> rsp_hold_1ms)
      else $error("non-final word without hold");

   // duties stay in percent range
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_a <= PCT_FULL && rsp_duty_b <= PCT_FULL)
      else $error("duty above 100");

   // a drive word holds one leg at 100 unless it is the estop release
   a_drive_leg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result && (rsp_duty_a != PCT_OFF || rsp_duty_b != PCT_OFF) |->
         rsp_duty_a == PCT_FULL || rsp_duty_b == PCT_FULL)
      else $error("drive word without a full leg");

endmodule
`default_nettype wire

>>> rtl/core/mschd_front.sv
`default_nettype none
module mschd_front
   import mschd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_estop,
   input  wire logic               req_forward,
   input  wire logic [SPEED_W-1:0] req_speed_mph_q8,
   input  wire logic               queue_full,
   output logic                    queue_push,
   output cmd_type                 queue_cmd
);

   logic                      last_forward_ff;
   logic                      last_forward_in;
   logic [SPEED_W-1:0]        speed_sat;
   logic [SPEED_W+LEVEL_W-1:0] speed_scaled;
   logic                      accept;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign queue_push = accept;

   // saturate at 128 mph, level = floor(speed * 100 / 128)
   always_comb begin
      speed_sat    = (req_speed_mph_q8 > SPEED_SAT) ? SPEED_SAT : req_speed_mph_q8;
      speed_scaled = (SPEED_W+LEVEL_W)'(speed_sat) * (SPEED_W+LEVEL_W)'(PCT_FULL);
   end

   // classify the word: estop, turn (brake first) or plain drive
   always_comb begin
      queue_cmd.fwd   = req_forward;
      queue_cmd.x     = speed_scaled[SPEED_SHIFT +: LEVEL_W];
      last_forward_in = last_forward_ff;
      if (req_estop) begin
         queue_cmd.kind = CMD_ESTOP;
      end else if (req_forward != last_forward_ff) begin
         queue_cmd.kind = CMD_TURN;
      end else begin
         queue_cmd.kind = CMD_DRIVE;
      end
      if (accept && !req_estop) begin
         last_forward_in = req_forward;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_forward_ff <= 1'b0;
      end else begin
         last_forward_ff <= last_forward_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/mschd_fifo.sv
`default_nettype none
module mschd_fifo
   import mschd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type wr_cmd,
   input  wire logic    pop,
   output cmd_type      rd_cmd,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_cmd  = slot_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/mschd_back.sv
`default_nettype none
module mschd_back
   import mschd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire cmd_type           head_cmd,
   input  wire logic              queue_empty,
   output logic                   queue_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [DUTY_W-1:0]      rsp_duty_a,
   output logic [DUTY_W-1:0]      rsp_duty_b,
   output logic                   rsp_hold_1ms,
   output logic                   rsp_last_result
);

   localparam int IDXP_W = LEVEL_W + 18;
   localparam int V_W    = 17;
   localparam int QP_W   = 2 * V_W;

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff;
   logic [PIDX_W-1:0]     i_ff;
   logic [POINT_W-1:0]    lo_ff, hi_ff;
   logic [LEVEL_W-1:0]    f_ff;
   logic [V_W-1:0]        v_ff;
   logic [DUTY_W-1:0]     duty_ff;

   logic                  rsp_valid_ff;
   logic [DUTY_W-1:0]     duty_a_ff, duty_b_ff;
   logic                  hold_ff, last_ff;

   logic                  out_free, out_load, out_hold_in, out_last_in;
   logic [DUTY_W-1:0]     out_a_in, out_b_in;
   logic                  lo_leg;

   tbl_bytes_type         tbl_bytes;
   logic [PIDX_W-1:0]     pt_idx;
   logic [POINT_W-1:0]    pt_val;
   logic [IDXP_W-1:0]     idx_prod;
   logic [11:0]           x27, i100;

   logic [POINT_W-1:0]    s_pt, m_pt, h_pt, base_pt, end_pt;
   logic [LEVEL_W-1:0]    dx;
   logic signed [8:0]     slope;
   logic signed [16:0]    prod;
   logic [15:0]           base_scaled;
   logic signed [17:0]    n_val;
   logic [14:0]           n_pos;
   logic                  tbl_end;
   logic [V_W-1:0]        v_calc;
   logic [QP_W-1:0]       q_prod;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_a      = duty_a_ff;
   assign rsp_duty_b      = duty_b_ff;
   assign rsp_hold_1ms    = hold_ff;
   assign rsp_last_result = last_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   // table point read port, one point a cycle
   assign tbl_bytes = cfg.tbl;
   always_comb begin
      pt_idx = (state_ff == ST_LOAD_HI) ? i_ff + 1'b1 : i_ff;
      pt_val = (pt_idx <= TABLE_LAST) ? tbl_bytes[pt_idx[PIDX_W-1:0]] : '0;
   end

   // segment index and fraction for the table
   always_comb begin
      idx_prod = IDXP_W'(cmd_ff.x) * IDXP_W'(IDX_RECIP);
      x27      = 12'(cmd_ff.x) * 12'd27;
      i100     = 12'(i_ff) * 12'd100;
   end

   // interpolation: n = base*scale + dx*(end - base), then rounding numerator
   always_comb begin
      s_pt = cfg.basic[7:0];
      m_pt = cfg.basic[15:8];
      h_pt = cfg.basic[23:16];
      if (cfg.mode) begin
         base_pt     = lo_ff;
         end_pt      = hi_ff;
         dx          = f_ff;
         base_scaled = 16'(lo_ff) * 16'd100;
      end else if (cmd_ff.x >= KNEE) begin
         base_pt     = m_pt;
         end_pt      = h_pt;
         dx          = cmd_ff.x - KNEE;
         base_scaled = 16'(m_pt) * 16'd50;
      end else begin
         base_pt     = s_pt;
         end_pt      = m_pt;
         dx          = cmd_ff.x;
         base_scaled = 16'(s_pt) * 16'd50;
      end
      slope   = $signed({1'b0, end_pt}) - $signed({1'b0, base_pt});
      prod    = $signed({1'b0, dx}) * slope;
      n_val   = $signed({2'b00, base_scaled}) + $signed({prod[16], prod});
      n_pos   = n_val[17] ? '0 : n_val[14:0];
      tbl_end = (cmd_ff.x == LEVEL_ZERO) || (i_ff == TABLE_LAST);
      if (!cfg.mode) begin
         v_calc = {n_pos, 2'b00} + V_W'(ROUND_BIAS);
      end else if (tbl_end) begin
         v_calc = V_W'(lo_ff) * V_W'(200);
      end else begin
         v_calc = {1'b0, n_pos, 1'b0} + V_W'(ROUND_BIAS);
      end
      q_prod = QP_W'(v_ff) * QP_W'(DIV_RECIP);
   end

   // sequencer: next state and output register loads
   always_comb begin
      state_in    = state_ff;
      queue_pop   = 1'b0;
      out_load    = 1'b0;
      out_a_in    = PCT_FULL;
      out_b_in    = PCT_FULL;
      out_hold_in = 1'b0;
      out_last_in = 1'b0;
      lo_leg      = !cmd_ff.fwd ^ cfg.reverse;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               state_in  = (head_cmd.kind == CMD_DRIVE) ? ST_SETUP : ST_BRAKE;
            end
         end
         ST_BRAKE: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_hold_in = 1'b1;
               state_in    = (cmd_ff.kind == CMD_ESTOP) ? ST_STOP : ST_SETUP;
            end
         end
         ST_STOP: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_a_in    = PCT_OFF;
               out_b_in    = PCT_OFF;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_SETUP:   state_in = cfg.mode ? ST_LOAD_LO : ST_CALC;
         ST_LOAD_LO: state_in = ST_LOAD_HI;
         ST_LOAD_HI: state_in = ST_CALC;
         ST_CALC:    state_in = ST_DIV;
         ST_DIV:     state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_a_in    = lo_leg ? PCT_FULL : duty_ff;
               out_b_in    = lo_leg ? duty_ff : PCT_FULL;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cmd_ff <= head_cmd;
      end
      if (state_ff == ST_SETUP) begin
         i_ff <= idx_prod[IDX_SHIFT +: PIDX_W];
      end
      if (state_ff == ST_LOAD_LO) begin
         lo_ff <= pt_val;
      end
      if (state_ff == ST_LOAD_HI) begin
         hi_ff <= pt_val;
         f_ff  <= LEVEL_W'(x27 - i100);
      end
      if (state_ff == ST_CALC) begin
         v_ff <= v_calc;
      end
      if (state_ff == ST_DIV) begin
         duty_ff <= q_prod[DIV_SHIFT +: DUTY_W];
      end
      if (out_load) begin
         duty_a_ff <= out_a_in;
         duty_b_ff <= out_b_in;
         hold_ff   <= out_hold_in;
         last_ff   <= out_last_in;
      end
   end

endmodule
`default_nettype wire
